### hw/rtl/dsf_pkg.sv
// Shared types, constants and lookup functions for the decimating sample framer.
// Used by every module in hw/rtl; depends on nothing else.
package dsf_pkg;

   localparam int SAMPLES_PER_FRAME = 10;
   localparam int SAMPLE_W = 24;
   localparam int SUM_W = 32;
   localparam int CNT_W = 4;
   localparam int FILL_W = 4;
   localparam int FN_W = 16;
   localparam int AUX_W = 48;
   localparam int WORD_W = 32;
   localparam int BCNT_W = 3;
   localparam int ITEM_CNT_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 2;

   localparam logic [7:0] MARK_START = 8'hAA;
   localparam logic [7:0] MARK_STOP = 8'h55;
   localparam logic [ITEM_CNT_W-1:0] LAST_ITEM = ITEM_CNT_W'(SAMPLES_PER_FRAME - 1);

   typedef logic [1:0] div_sel_type;
   localparam div_sel_type SEL_DIV1 = 2'd0;
   localparam div_sel_type SEL_DIV2 = 2'd1;
   localparam div_sel_type SEL_DIV5 = 2'd2;
   localparam div_sel_type SEL_DIV10 = 2'd3;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_CH0_DIV = 3'd0;
   localparam csr_index_type CSR_CH1_DIV = 3'd1;
   localparam csr_index_type CSR_ADC_PRESENT = 3'd2;
   localparam csr_index_type CSR_ACC_PRESENT = 3'd3;
   localparam csr_index_type CSR_RECORDING = 3'd4;

   typedef logic [SAMPLES_PER_FRAME-1:0][SAMPLE_W-1:0] slot_array_type;

   typedef struct packed {
      div_sel_type ch0_div;
      div_sel_type ch1_div;
      logic        adc_present;
      logic        acc_present;
      logic        recording;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] ch0_sample;
      logic signed [SAMPLE_W-1:0] ch1_sample;
      logic [15:0]                adc_word;
      logic [15:0]                acc_x;
      logic [15:0]                acc_y;
      logic [15:0]                acc_z;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] frame_word;
      logic [BCNT_W-1:0] byte_count;
      logic              last_of_frame;
   } rsp_payload_type;

   // Three or four frame bytes handed from the framer to the packer.
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [BCNT_W-1:0] len;
      logic [WORD_W-1:0] data;
   } piece_type;

   function automatic logic [CNT_W-1:0] div_count(div_sel_type sel);
      logic [CNT_W-1:0] r;
      unique case (sel)
         SEL_DIV1: r = 4'd1;
         SEL_DIV2: r = 4'd2;
         SEL_DIV5: r = 4'd5;
         default: r = 4'd10;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] div_shift(div_sel_type sel);
      logic [2:0] r;
      unique case (sel)
         SEL_DIV1: r = 3'd0;
         SEL_DIV2: r = 3'd1;
         SEL_DIV5: r = 3'd3;
         default: r = 3'd4;
      endcase
      return r;
   endfunction

   function automatic logic [FILL_W-1:0] slot_count(div_sel_type sel);
      logic [FILL_W-1:0] r;
      unique case (sel)
         SEL_DIV1: r = 4'd10;
         SEL_DIV2: r = 4'd5;
         SEL_DIV5: r = 4'd2;
         default: r = 4'd1;
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/decimating_sample_framer_top.sv
// Top level of the decimating sample framer: configuration registers, item counter, lanes,
// framer and packer. Depends on dsf_pkg, dsf_lane, dsf_framer and dsf_packer.
//
// Each req word carries one 24-bit sample per converter channel and four auxiliary words.
// Two lanes accumulate and decimate their channel by 1, 2, 5 or 10 and keep up to ten averages.
// Every tenth word closes a frame: when recording is set, the framer copies both lanes and
// the frame goes out on rsp as 4-byte little-endian words, the last one flagged, the partial
// final word carrying its byte count. Frames hold 13 + 3 * (slots0 + slots1) bytes, at most
// 73 bytes or 19 words.
// A req word is taken in every cycle, except that the tenth word of a frame waits while the
// previous frame is still being sequenced. The framer hands out one piece of up to four bytes
// per cycle while the packer can take it; the first rsp word of a frame passes through the
// go flag, the framer's head state, the packer buffer and the output register. When rsp_ready
// is low the packer holds its word and stops taking pieces once its seven-byte buffer is full,
// which in turn may hold the tenth req word of the next frame.
// Synchronous reset clears the counters, sums, frame number and registers; stored averages
// are not cleared. CSR writes take effect at once and belong in idle periods.
module decimating_sample_framer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  dsf_pkg::req_payload_type              req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output dsf_pkg::rsp_payload_type              rsp_payload,
   input  logic                                  csr_we,
   input  dsf_pkg::csr_index_type                csr_index,
   input  logic [dsf_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import dsf_pkg::*;

   cfg_type                 cfg_ff, cfg_in;
   logic [ITEM_CNT_W-1:0]   item_cnt_ff, item_cnt_in;
   logic                    accept, frame_done, busy, piece_ready;
   piece_type               piece;
   slot_array_type          lane0_slots, lane1_slots;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CH0_DIV: cfg_in.ch0_div = csr_wdata;
            CSR_CH1_DIV: cfg_in.ch1_div = csr_wdata;
            CSR_ADC_PRESENT: cfg_in.adc_present = csr_wdata[0];
            CSR_ACC_PRESENT: cfg_in.acc_present = csr_wdata[0];
            CSR_RECORDING: cfg_in.recording = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
      req_ready = !((item_cnt_ff == LAST_ITEM) && busy);
      accept = req_valid && req_ready;
      frame_done = accept && (item_cnt_ff == LAST_ITEM);
      item_cnt_in = item_cnt_ff;
      if (accept) begin
         item_cnt_in = frame_done ? '0 : item_cnt_ff + ITEM_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         item_cnt_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         item_cnt_ff <= item_cnt_in;
      end
   end

   dsf_lane u_lane0 (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .frame_end (frame_done),
      .sel       (cfg_ff.ch0_div),
      .sample    (req_payload.ch0_sample),
      .slots     (lane0_slots)
   );

   dsf_lane u_lane1 (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .frame_end (frame_done),
      .sel       (cfg_ff.ch1_div),
      .sample    (req_payload.ch1_sample),
      .slots     (lane1_slots)
   );

   dsf_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .frame_done  (frame_done),
      .req_payload (req_payload),
      .lane0_slots (lane0_slots),
      .lane1_slots (lane1_slots),
      .piece       (piece),
      .piece_ready (piece_ready),
      .busy        (busy)
   );

   dsf_packer u_packer (
      .clock       (clock),
      .reset       (reset),
      .piece       (piece),
      .piece_ready (piece_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Only the final word of a frame may be partial.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.byte_count != 3'd0) &&
                    (rsp_payload.last_of_frame || (rsp_payload.byte_count == 3'd4)))
      else $error("partial rsp word before end of frame");

   // The input stalls only on the word that closes a frame.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (item_cnt_ff == LAST_ITEM))
      else $error("req stalled outside frame boundary");

   // A frame closes only while the framer is free.
   assert property (@(posedge clock) disable iff (reset)
      frame_done |-> !busy)
      else $error("frame closed while framer busy");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

### hw/rtl/dsf_lane.sv
// One converter channel: accumulates samples, decimates and stores the averages of a frame.
// Depends on dsf_pkg.
module dsf_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               frame_end,
   input  dsf_pkg::div_sel_type               sel,
   input  logic signed [dsf_pkg::SAMPLE_W-1:0] sample,
   output dsf_pkg::slot_array_type            slots
);
   import dsf_pkg::*;

   logic [SUM_W-1:0]        sum_ff, sum_in, sum_next;
   logic [CNT_W-1:0]        cnt_ff, cnt_in, cnt_next;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   slot_array_type          store_ff, store_in;
   logic signed [SUM_W-1:0] shifted;
   logic                    done;

   always_comb begin
      sum_next = sum_ff + {{(SUM_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      cnt_next = cnt_ff + CNT_W'(1);
      done = cnt_next >= div_count(sel);
      shifted = $signed(sum_next) >>> div_shift(sel);
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      fill_in = fill_ff;
      store_in = store_ff;
      if (accept) begin
         if (done) begin
            sum_in = '0;
            cnt_in = '0;
            if (fill_ff < FILL_W'(SAMPLES_PER_FRAME)) begin
               store_in[fill_ff] = shifted[SAMPLE_W-1:0];
               fill_in = fill_ff + FILL_W'(1);
            end
         end else begin
            sum_in = sum_next;
            cnt_in = cnt_next;
         end
         if (frame_end) begin
            fill_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         fill_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   assign slots = store_ff;

endmodule

### hw/rtl/dsf_packer.sv
// Byte packer and output register: gathers frame bytes into 4-byte little-endian words.
// Depends on dsf_pkg.
module dsf_packer (
   input  logic                     clock,
   input  logic                     reset,
   input  dsf_pkg::piece_type       piece,
   output logic                     piece_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dsf_pkg::rsp_payload_type rsp_payload
);
   import dsf_pkg::*;

   localparam int BUF_BYTES = 7;
   localparam int BUF_W = 8 * BUF_BYTES;

   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [2:0]       cnt_ff, cnt_in, emit_n, rem;
   logic             end_ff, end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;
   logic             out_free, can_emit, is_last;
   logic [3:0]       fill_sum;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      can_emit = out_free && ((cnt_ff >= 3'd4) || (end_ff && (cnt_ff != 3'd0)));
      is_last = end_ff && (cnt_ff <= 3'd4);
      emit_n = 3'd0;
      if (can_emit) begin
         emit_n = (cnt_ff >= 3'd4) ? 3'd4 : cnt_ff;
      end
      rem = cnt_ff - emit_n;
      fill_sum = {1'b0, rem} + {1'b0, piece.len};
      piece_ready = !end_ff && (fill_sum <= 4'(BUF_BYTES));
      buf_in = buf_ff >> {emit_n, 3'b000};
      cnt_in = rem;
      end_in = end_ff;
      if (piece.valid && piece_ready) begin
         buf_in = buf_in | (BUF_W'(piece.data) << {rem, 3'b000});
         cnt_in = fill_sum[2:0];
         end_in = piece.last;
      end else if (can_emit && is_last) begin
         end_in = 1'b0;
      end
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (can_emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.frame_word = buf_ff[WORD_W-1:0];
         rsp_in.byte_count = emit_n;
         rsp_in.last_of_frame = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         end_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         buf_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         end_ff <= end_in;
         rsp_valid_ff <= rsp_valid_in;
         buf_ff <= buf_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hw/rtl/dsf_framer.sv
// Merging stage: snapshots both lanes after a recorded frame and sequences it into byte pieces.
// Depends on dsf_pkg.
module dsf_framer (
   input  logic                     clock,
   input  logic                     reset,
   input  dsf_pkg::cfg_type         cfg,
   input  logic                     frame_done,
   input  dsf_pkg::req_payload_type req_payload,
   input  dsf_pkg::slot_array_type  lane0_slots,
   input  dsf_pkg::slot_array_type  lane1_slots,
   output dsf_pkg::piece_type       piece,
   input  logic                     piece_ready,
   output logic                     busy
);
   import dsf_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_HEAD  = 7'b0000010,
      ST_CH0   = 7'b0000100,
      ST_CH1   = 7'b0001000,
      ST_AUX_A = 7'b0010000,
      ST_AUX_B = 7'b0100000,
      ST_TAIL  = 7'b1000000
   } fstate_type;

   fstate_type        state_ff, state_in;
   logic              go_ff, go_in;
   logic [FN_W-1:0]   fn_ff, fn_in, head_fn_ff, head_fn_in;
   logic [AUX_W-1:0]  aux_ff, aux_in;
   logic [FILL_W-1:0] left0_ff, left0_in, left1_ff, left1_in;
   slot_array_type    fb0_ff, fb0_in, fb1_ff, fb1_in;

   always_comb begin
      go_in = frame_done && cfg.recording;
      fn_in = fn_ff;
      head_fn_in = head_fn_ff;
      aux_in = aux_ff;
      left0_in = left0_ff;
      left1_in = left1_ff;
      fb0_in = fb0_ff;
      fb1_in = fb1_ff;
      state_in = state_ff;
      piece = '0;

      if (frame_done) begin
         fn_in = fn_ff + FN_W'(1);
         head_fn_in = fn_ff;
         left0_in = slot_count(cfg.ch0_div);
         left1_in = slot_count(cfg.ch1_div);
         priority if (cfg.adc_present && cfg.acc_present) begin
            aux_in = {req_payload.acc_y, req_payload.acc_x, req_payload.adc_word};
         end else if (cfg.acc_present) begin
            aux_in = {req_payload.acc_z, req_payload.acc_y, req_payload.acc_x};
         end else if (cfg.adc_present) begin
            aux_in = {32'h0, req_payload.adc_word};
         end else begin
            aux_in = '0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (go_ff) begin
               fb0_in = lane0_slots;
               fb1_in = lane1_slots;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            piece = '{valid: 1'b1, last: 1'b0, len: 3'd4,
                      data: {head_fn_ff, MARK_START, MARK_START}};
            if (piece_ready) begin
               state_in = ST_CH0;
            end
         end
         ST_CH0: begin
            piece = '{valid: 1'b1, last: 1'b0, len: 3'd3, data: {8'h00, fb0_ff[0]}};
            if (piece_ready) begin
               fb0_in = {SAMPLE_W'(0), fb0_ff[SAMPLES_PER_FRAME-1:1]};
               left0_in = left0_ff - FILL_W'(1);
               if (left0_ff == FILL_W'(1)) begin
                  state_in = ST_CH1;
               end
            end
         end
         ST_CH1: begin
            piece = '{valid: 1'b1, last: 1'b0, len: 3'd3, data: {8'h00, fb1_ff[0]}};
            if (piece_ready) begin
               fb1_in = {SAMPLE_W'(0), fb1_ff[SAMPLES_PER_FRAME-1:1]};
               left1_in = left1_ff - FILL_W'(1);
               if (left1_ff == FILL_W'(1)) begin
                  state_in = ST_AUX_A;
               end
            end
         end
         ST_AUX_A: begin
            piece = '{valid: 1'b1, last: 1'b0, len: 3'd3, data: {8'h00, aux_ff[23:0]}};
            if (piece_ready) begin
               state_in = ST_AUX_B;
            end
         end
         ST_AUX_B: begin
            piece = '{valid: 1'b1, last: 1'b0, len: 3'd3, data: {8'h00, aux_ff[47:24]}};
            if (piece_ready) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            piece = '{valid: 1'b1, last: 1'b1, len: 3'd3,
                      data: {8'h00, MARK_STOP, 16'h0000}};
            if (piece_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      busy = go_ff || (state_ff != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff <= 1'b0;
         fn_ff <= '0;
         left0_ff <= '0;
         left1_ff <= '0;
      end else begin
         state_ff <= state_in;
         go_ff <= go_in;
         fn_ff <= fn_in;
         left0_ff <= left0_in;
         left1_ff <= left1_in;
      end
   end

   always_ff @(posedge clock) begin
      head_fn_ff <= head_fn_in;
      aux_ff <= aux_in;
      fb0_ff <= fb0_in;
      fb1_ff <= fb1_in;
   end

endmodule

### bench/tb_decimating_sample_framer_top.sv
// Self-checking bench for decimating_sample_framer_top: random and corner samples under
// changing divider, auxiliary and recording settings, checked word by word against a
// behavioral frame predictor. Depends on dsf_pkg and the RTL under hw/rtl.
module tb_decimating_sample_framer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dsf_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 300000;
   localparam int TARGET_ITEMS = 200;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_CH0_DIV;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   req_payload_type pending_items [$];
   rsp_payload_type expected_words [$];

   // Shadow of the block's registers and decimation state.
   div_sel_type cfg_div [2];
   bit cfg_adc, cfg_acc, cfg_rec;
   logic [31:0] chan_sum [2];
   logic [3:0] chan_count [2];
   logic [23:0] avg_store [2][SAMPLES_PER_FRAME];
   int store_fill [2];
   logic [3:0] frame_item;
   logic [15:0] frame_seq;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_left = 0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int mismatch_count = 0;
   int items_accepted = 0;
   int words_checked = 0;
   int frames_built = 0;
   int frames_sent = 0;
   int cycle_count = 0;

   decimating_sample_framer_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [3:0] decim_factor(div_sel_type sel);
      case (sel)
         SEL_DIV1: return 4'd1;
         SEL_DIV2: return 4'd2;
         SEL_DIV5: return 4'd5;
         default: return 4'd10;
      endcase
   endfunction

   function automatic int decim_shift(div_sel_type sel);
      case (sel)
         SEL_DIV1: return 0;
         SEL_DIV2: return 1;
         SEL_DIV5: return 3;
         default: return 4;
      endcase
   endfunction

   task automatic predict_words(input req_payload_type item);
      logic [23:0] sample;
      logic signed [31:0] shifted;
      logic [7:0] frame_bytes [$];
      logic [15:0] aux [3];
      rsp_payload_type word;
      int slots;
      int lanes;
      for (int c = 0; c < 2; c++) begin
         sample = (c == 0) ? item.ch0_sample : item.ch1_sample;
         chan_sum[c] = chan_sum[c] + {{8{sample[23]}}, sample};
         chan_count[c] = chan_count[c] + 4'd1;
         if (chan_count[c] >= decim_factor(cfg_div[c])) begin
            shifted = $signed(chan_sum[c]) >>> decim_shift(cfg_div[c]);
            chan_sum[c] = '0;
            chan_count[c] = '0;
            if (store_fill[c] < SAMPLES_PER_FRAME) begin
               avg_store[c][store_fill[c]] = shifted[23:0];
               store_fill[c]++;
            end
         end
      end
      frame_item = frame_item + 4'd1;
      if (frame_item < SAMPLES_PER_FRAME) return;
      frame_item = '0;
      store_fill[0] = 0;
      store_fill[1] = 0;
      frame_bytes = '{MARK_START, MARK_START, frame_seq[7:0], frame_seq[15:8]};
      for (int c = 0; c < 2; c++) begin
         slots = SAMPLES_PER_FRAME / decim_factor(cfg_div[c]);
         for (int k = 0; k < slots; k++) begin
            frame_bytes.push_back(avg_store[c][k][7:0]);
            frame_bytes.push_back(avg_store[c][k][15:8]);
            frame_bytes.push_back(avg_store[c][k][23:16]);
         end
      end
      case ({cfg_adc, cfg_acc})
         2'b11: aux = '{item.adc_word, item.acc_x, item.acc_y};
         2'b01: aux = '{item.acc_x, item.acc_y, item.acc_z};
         2'b10: aux = '{item.adc_word, 16'h0000, 16'h0000};
         default: aux = '{16'h0000, 16'h0000, 16'h0000};
      endcase
      for (int k = 0; k < 3; k++) begin
         frame_bytes.push_back(aux[k][7:0]);
         frame_bytes.push_back(aux[k][15:8]);
      end
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(MARK_STOP);
      frame_seq = frame_seq + 16'd1;
      frames_built++;
      if (!cfg_rec) return;
      frames_sent++;
      for (int base = 0; base < frame_bytes.size(); base += 4) begin
         lanes = (frame_bytes.size() - base < 4) ? frame_bytes.size() - base : 4;
         word = '0;
         for (int b = 0; b < lanes; b++) word.frame_word[8*b +: 8] = frame_bytes[base + b];
         word.byte_count = BCNT_W'(lanes);
         word.last_of_frame = (base + 4 >= frame_bytes.size());
         expected_words.push_back(word);
      end
   endtask

   // Sender: one word in flight, refilled from the pending queue.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_words(req_payload);
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_payload <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each accepted word and paces rsp_ready.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               $error("unexpected rsp word %h", rsp_payload);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_payload.frame_word !== want.frame_word) begin
                  $error("frame_word: expected %h, got %h", want.frame_word,
                         rsp_payload.frame_word);
                  mismatch_count++;
               end
               if (rsp_payload.byte_count !== want.byte_count) begin
                  $error("byte_count: expected %0d, got %0d", want.byte_count,
                         rsp_payload.byte_count);
                  mismatch_count++;
               end
               if (rsp_payload.last_of_frame !== want.last_of_frame) begin
                  $error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
                         rsp_payload.last_of_frame);
                  mismatch_count++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_armed && !hold_done) begin
            hold_left <= LONG_HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words outstanding.", cycle_count,
                  expected_words.size());
         $display("[decimating_sample_framer_top] ERROR");
         $finish;
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CH0_DIV: cfg_div[0] = val;
         CSR_CH1_DIV: cfg_div[1] = val;
         CSR_ADC_PRESENT: cfg_adc = val[0];
         CSR_ACC_PRESENT: cfg_acc = val[0];
         default: cfg_rec = val[0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(input div_sel_type d0, input div_sel_type d1,
                                 input bit adc, input bit acc, input bit rec);
      write_csr(CSR_CH0_DIV, d0);
      write_csr(CSR_CH1_DIV, d1);
      write_csr(CSR_ADC_PRESENT, {1'b0, adc});
      write_csr(CSR_ACC_PRESENT, {1'b0, acc});
      write_csr(CSR_RECORDING, {1'b0, rec});
      @(negedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         1: begin
            sender_idle_pct = 72;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 72;
         end
         3: begin
            sender_idle_pct = 14;
            receiver_stall_pct = 14;
         end
         default: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
      endcase
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [23:0] random_sample();
      case ($urandom_range(7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(31));
         3: return -24'($urandom_range(31));
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] random_aux();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic queue_random_items(input int count);
      req_payload_type item;
      for (int k = 0; k < count; k++) begin
         item.ch0_sample = random_sample();
         item.ch1_sample = random_sample();
         item.adc_word = random_aux();
         item.acc_x = random_aux();
         item.acc_y = random_aux();
         item.acc_z = random_aux();
         pending_items.push_back(item);
      end
   endtask

   initial begin
      logic [23:0] corner_vals [8];
      req_payload_type item;
      int queued;
      int phase_no;
      corner_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                      24'h000001, 24'hFFFFFE, 24'h555555, 24'hAAAAAA};
      cfg_div = '{SEL_DIV1, SEL_DIV1};
      {cfg_adc, cfg_acc, cfg_rec} = 3'b000;
      chan_sum = '{32'd0, 32'd0};
      chan_count = '{4'd0, 4'd0};
      store_fill = '{0, 0};
      frame_item = '0;
      frame_seq = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The first frame runs undecimated so that every store slot holds a value.
      apply_settings(SEL_DIV1, SEL_DIV1, 1'b1, 1'b1, 1'b1);
      set_idling(0);
      for (int k = 0; k < SAMPLES_PER_FRAME; k++) begin
         item.ch0_sample = corner_vals[k % 8];
         item.ch1_sample = corner_vals[(k + 1) % 8];
         item.adc_word = k[0] ? 16'hFFFF : 16'h0000;
         item.acc_x = ~item.adc_word;
         item.acc_y = 16'hA55A;
         item.acc_z = 16'h1234;
         pending_items.push_back(item);
      end
      wait_idle();

      apply_settings(SEL_DIV10, SEL_DIV10, 1'b0, 1'b1, 1'b1);
      for (int k = 0; k < SAMPLES_PER_FRAME; k++) begin
         item.ch0_sample = 24'h7FFFFF;
         item.ch1_sample = 24'h800000;
         item.adc_word = 16'h5A5A;
         item.acc_x = 16'hFFFF;
         item.acc_y = 16'h0000;
         item.acc_z = 16'hFFFF;
         pending_items.push_back(item);
      end
      wait_idle();
      queued = 2 * SAMPLES_PER_FRAME;

      // This phase ends mid-frame, so the next one changes dividers on running counts.
      apply_settings(SEL_DIV5, SEL_DIV2, 1'b1, 1'b0, 1'b1);
      set_idling(1);
      queue_random_items(13);
      wait_idle();
      apply_settings(SEL_DIV2, SEL_DIV5, 1'b0, 1'b0, 1'b1);
      set_idling(2);
      queue_random_items(17);
      wait_idle();
      apply_settings(div_sel_type'($urandom_range(3)), div_sel_type'($urandom_range(3)),
                     1'b1, 1'b1, 1'b0);
      set_idling(3);
      queue_random_items(10);
      wait_idle();
      queued += 40;

      // Long receiver hold-off while the sender keeps offering words.
      apply_settings(SEL_DIV1, SEL_DIV1, 1'b1, 1'b1, 1'b1);
      set_idling(0);
      hold_armed = 1'b1;
      queue_random_items(40);
      wait_idle();
      queued += 40;

      phase_no = 0;
      while (queued < TARGET_ITEMS) begin
         apply_settings(div_sel_type'($urandom_range(3)), div_sel_type'($urandom_range(3)),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        $urandom_range(99) < 85);
         set_idling(phase_no % 4);
         item.adc_word = 16'($urandom_range(6, 34));
         queue_random_items(item.adc_word);
         queued += item.adc_word;
         phase_no++;
         wait_idle();
      end

      $display("Sent %0d samples in %0d settings phases; %0d frames built, %0d emitted.",
               items_accepted, phase_no + 6, frames_built, frames_sent);
      $display("Checked %0d rsp words with %0d mismatches.", words_checked, mismatch_count);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("[decimating_sample_framer_top] OK");
      end else begin
         $display("[decimating_sample_framer_top] ERROR");
      end
      $finish;
   end

endmodule

### decimating_sample_framer_top.f
hw/rtl/dsf_pkg.sv
hw/rtl/dsf_lane.sv
hw/rtl/dsf_packer.sv
hw/rtl/dsf_framer.sv
hw/rtl/decimating_sample_framer_top.sv
bench/tb_decimating_sample_framer_top.sv
